// ===== design/dconv_pkg.sv =====
package dconv_pkg;

  localparam int unsigned MaxImageWidth  = 64;
  localparam int unsigned MaxImageHeight = 64;
  localparam int unsigned MaxInChannels  = 16;
  localparam int unsigned MaxOutChannels = 16;
  localparam int unsigned MaxKernel      = 8;

  localparam int unsigned PixDepth = MaxImageHeight * MaxImageWidth * MaxInChannels;
  localparam int unsigned WgtDepth = MaxOutChannels * MaxKernel * MaxKernel * MaxInChannels;
  localparam int unsigned PixAw = $clog2(PixDepth);
  localparam int unsigned WgtAw = $clog2(WgtDepth);
  localparam int unsigned RowW = $clog2(MaxImageHeight);
  localparam int unsigned ColW = $clog2(MaxImageWidth);
  localparam int unsigned IcW  = $clog2(MaxInChannels);
  localparam int unsigned OcW  = $clog2(MaxOutChannels);
  localparam int unsigned KW   = $clog2(MaxKernel);

  localparam int unsigned AccW = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 5;

  typedef enum logic [1:0] {
    ActLoadPixel  = 2'd0,
    ActLoadWeight = 2'd1,
    ActLoadBias   = 2'd2,
    ActCompute    = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegKernelWidth  = 3'd0,
    RegKernelHeight = 3'd1,
    RegDilationH    = 3'd2,
    RegDilationV    = 3'd3,
    RegStrideH      = 3'd4,
    RegStrideV      = 3'd5,
    RegBiasOn       = 3'd6,
    RegInChannels   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [3:0]         out_channel;
    logic [3:0]         in_channel;
    logic [2:0]         kernel_row;
    logic [2:0]         kernel_col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic               saturated;
    logic               window_error;
  } out_item_t;

  typedef struct packed {
    logic [3:0] kernel_width;
    logic [3:0] kernel_height;
    logic [3:0] dil_col;
    logic [3:0] dil_row;
    logic [3:0] step_col;
    logic [3:0] step_row;
    logic       bias_on;
    logic [4:0] in_channels;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic store_load;
    logic start;
    logic mac;
    logic mac_last;
    logic finish;
    logic bad;
    logic [RowW-1:0] pr;
    logic [ColW-1:0] pc;
    logic [KW-1:0]   kr;
    logic [KW-1:0]   kc;
    logic [IcW-1:0]  ic;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mac_busy;
  } dp_status_t;

endpackage

// ===== design/dconv_if.sv =====
interface dconv_in_if;
  import dconv_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dconv_out_if;
  import dconv_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/direct_conv2d_dot_product.sv =====
// Direct 2D convolution, dilated and strided, Q8.8, on an HWC pixel store.
// Input channel: beats with action 0/1/2 write a pixel, weight or bias
// entry and give no result; action 3 computes one output point and gives
// exactly one result beat on the output channel.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i; the user
// must write only while the block is idle, which the block does not enforce.
// Flow: a load is written when taken, and the next beat may follow at once.
// A compute runs one multiply-accumulate per kernel tap and input channel, one
// per cycle through the pixel and weight memory read ports, then waits in a
// drain state until the read and multiply registers are empty, and registers
// the rounded result into the output register in a finish state.
// A window outside the store or an empty kernel skips the multiply-accumulates
// and goes straight to the drain and finish states.
// One item is in work at a time. The result sits in an output register;
// while it is not taken, no new beat is accepted.
// Reset clears control and sets the configuration to its defaults; stores hold undefined data until
// loaded.
module direct_conv2d_dot_product (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dconv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dconv_pkg::CfgDataW-1:0] cfg_data_i,
  dconv_in_if.sink                      in_if,
  dconv_out_if.source                   out_if
);
  import dconv_pkg::*;

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{kernel_width: 4'd3, kernel_height: 4'd3, dil_col: 4'd1,
                 dil_row: 4'd1, step_col: 4'd1, step_row: 4'd1,
                 bias_on: 1'b0, in_channels: 5'd1};
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegKernelWidth:  cfg_q.kernel_width  <= cfg_data_i[3:0];
        RegKernelHeight: cfg_q.kernel_height <= cfg_data_i[3:0];
        RegDilationH:    cfg_q.dil_col       <= cfg_data_i[3:0];
        RegDilationV:    cfg_q.dil_row       <= cfg_data_i[3:0];
        RegStrideH:      cfg_q.step_col      <= cfg_data_i[3:0];
        RegStrideV:      cfg_q.step_row      <= cfg_data_i[3:0];
        RegBiasOn:       cfg_q.bias_on       <= cfg_data_i[0];
        RegInChannels:   cfg_q.in_channels   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dconv_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .in_data_i  (in_if.data),
    .out_busy_i (out_if.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dconv_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .in_data_i   (in_if.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.data)
  );

endmodule

// ===== design/dconv_ctrl.sv =====
module dconv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dconv_pkg::cfg_t      cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dconv_pkg::in_item_t  in_data_i,
  input  logic                 out_busy_i,
  input  dconv_pkg::dp_status_t status_i,
  output dconv_pkg::dp_cmd_t   cmd_o
);
  import dconv_pkg::*;

  typedef enum logic [1:0] {StIdle, StRun, StDrain, StDone} state_e;

  state_e         state_q, state_d;
  logic [KW-1:0]  kr_q, kr_d, kc_q, kc_d;
  logic [IcW-1:0] ic_q, ic_d;
  logic [KW:0]    kw_q, kw_d, kh_q, kh_d;
  logic [4:0]     nc_q, nc_d;
  logic [9:0]     r0_q, r0_d, c0_q, c0_d;
  logic [10:0]    rlast, clast;
  logic [KW:0]    kw_c, kh_c;
  logic [4:0]     nc_c;
  logic [9:0]     r0_c, c0_c;
  logic           bad_c, empty_c, last_c;
  logic [10:0]    prw, pcw;

  always_comb begin
    kw_c = (cfg_i.kernel_width > 4'(MaxKernel)) ? (KW+1)'(MaxKernel)
                                                 : (KW+1)'(cfg_i.kernel_width);
    kh_c = (cfg_i.kernel_height > 4'(MaxKernel)) ? (KW+1)'(MaxKernel)
                                                  : (KW+1)'(cfg_i.kernel_height);
    nc_c = (cfg_i.in_channels > 5'(MaxInChannels)) ? 5'(MaxInChannels) : cfg_i.in_channels;
    r0_c = 10'(in_data_i.row) * 10'(cfg_i.step_row);
    c0_c = 10'(in_data_i.col) * 10'(cfg_i.step_col);
    rlast = 11'(r0_c) + 11'(kh_c - 1'b1) * 11'(cfg_i.dil_row);
    clast = 11'(c0_c) + 11'(kw_c - 1'b1) * 11'(cfg_i.dil_col);
    bad_c = (kw_c != '0 && kh_c != '0 &&
             (rlast >= 11'(MaxImageHeight) || clast >= 11'(MaxImageWidth)));
    empty_c = (kw_c == '0) || (kh_c == '0) || (nc_c == '0);
    prw = 11'(r0_q) + 11'(kr_q) * 11'(cfg_i.dil_row);
    pcw = 11'(c0_q) + 11'(kc_q) * 11'(cfg_i.dil_col);
    last_c = (5'(ic_q) == nc_q - 1'b1) && ((KW+1)'(kc_q) == kw_q - 1'b1) &&
             ((KW+1)'(kr_q) == kh_q - 1'b1);
  end

  assign in_ready_o = (state_q == StIdle) && !out_busy_i;

  always_comb begin
    state_d = state_q;
    kr_d = kr_q; kc_d = kc_q; ic_d = ic_q;
    kw_d = kw_q; kh_d = kh_q; nc_d = nc_q; r0_d = r0_q; c0_d = c0_q;
    cmd_o = '0;
    cmd_o.pr = prw[RowW-1:0];
    cmd_o.pc = pcw[ColW-1:0];
    cmd_o.kr = kr_q;
    cmd_o.kc = kc_q;
    cmd_o.ic = ic_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          if (in_data_i.action != ActCompute) begin
            cmd_o.store_load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            cmd_o.bad = bad_c || (32'(in_data_i.out_channel) >= MaxOutChannels);
            kr_d = '0; kc_d = '0; ic_d = '0;
            kw_d = kw_c; kh_d = kh_c; nc_d = nc_c; r0_d = r0_c; c0_d = c0_c;
            if (cmd_o.bad || empty_c) state_d = StDrain;
            else state_d = StRun;
          end
        end
      end
      StRun: begin
        cmd_o.mac = 1'b1;
        cmd_o.mac_last = last_c;
        if (last_c) begin
          state_d = StDrain;
        end else if (5'(ic_q) != nc_q - 1'b1) begin
          ic_d = ic_q + 1'b1;
        end else begin
          ic_d = '0;
          if ((KW+1)'(kc_q) != kw_q - 1'b1) begin
            kc_d = kc_q + 1'b1;
          end else begin
            kc_d = '0;
            kr_d = kr_q + 1'b1;
          end
        end
      end
      StDrain: begin
        if (!status_i.mac_busy) state_d = StDone;
      end
      StDone: begin
        cmd_o.finish = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kr_q <= kr_d; kc_q <= kc_d; ic_q <= ic_d;
    kw_q <= kw_d; kh_q <= kh_d; nc_q <= nc_d; r0_q <= r0_d; c0_q <= c0_d;
  end

endmodule

// ===== design/dconv_datapath.sv =====
module dconv_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dconv_pkg::cfg_t       cfg_i,
  input  dconv_pkg::in_item_t   in_data_i,
  input  dconv_pkg::dp_cmd_t    cmd_i,
  output dconv_pkg::dp_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output dconv_pkg::out_item_t  out_data_o
);
  import dconv_pkg::*;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  logic signed [15:0] pix_mem [PixDepth];
  logic signed [15:0] wgt_mem [WgtDepth];
  logic signed [15:0] bias_mem [MaxOutChannels];

  logic [PixAw-1:0] pix_waddr, pix_raddr;
  logic [WgtAw-1:0] wgt_waddr, wgt_raddr;
  logic signed [15:0] pix_q, wgt_q;
  logic [OcW-1:0] oc_q;
  logic           bad_q;
  logic           rd_v_q, rd_last_q, mul_v_q, mul_last_q;
  logic signed [31:0] prod_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic           sat_q, sat_d;
  logic signed [AccW:0] sum;
  logic signed [AccW-1:0] rnd;
  logic signed [AccW-1:0] res;
  logic           out_valid_q;
  out_item_t      out_q, out_d;

  assign pix_waddr = {in_data_i.row, in_data_i.col, in_data_i.in_channel};
  assign wgt_waddr = {in_data_i.out_channel, in_data_i.kernel_row, in_data_i.kernel_col,
                      in_data_i.in_channel};
  assign pix_raddr = {cmd_i.pr, cmd_i.pc, cmd_i.ic};
  assign wgt_raddr = {oc_q, cmd_i.kr, cmd_i.kc, cmd_i.ic};

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_load) begin
      case (action_e'(in_data_i.action))
        ActLoadPixel:  pix_mem[pix_waddr] <= in_data_i.value;
        ActLoadWeight: wgt_mem[wgt_waddr] <= in_data_i.value;
        ActLoadBias:   bias_mem[in_data_i.out_channel] <= in_data_i.value;
        default: ;
      endcase
    end
    pix_q <= pix_mem[pix_raddr];
    wgt_q <= wgt_mem[wgt_raddr];
    prod_q <= 32'(pix_q) * 32'(wgt_q);
    if (cmd_i.start) begin
      oc_q  <= in_data_i.out_channel;
      bad_q <= cmd_i.bad;
    end
    acc_q <= acc_d;
    sat_q <= sat_d;
    out_q <= out_d;
  end

  always_comb begin
    acc_d = acc_q;
    sat_d = sat_q;
    sum = 41'(acc_q) + 41'(prod_q);
    if (cmd_i.start) begin
      acc_d = cfg_i.bias_on ? (AccW'(bias_mem[in_data_i.out_channel]) <<< 8) : '0;
      sat_d = 1'b0;
    end else if (mul_v_q) begin
      if (sum > 41'(AccMax)) begin
        acc_d = AccMax; sat_d = 1'b1;
      end else if (sum < 41'(AccMin)) begin
        acc_d = AccMin; sat_d = 1'b1;
      end else begin
        acc_d = sum[AccW-1:0];
      end
    end
  end

  always_comb begin
    rnd = acc_q + AccW'(128);
    if (acc_q > AccMax - AccW'(128)) res = AccMax;
    else res = rnd >>> 8;
    out_d = out_q;
    if (cmd_i.finish) begin
      if (bad_q) begin
        out_d = '{out_value: '0, saturated: 1'b0, window_error: 1'b1};
      end else if (res > AccW'(32767)) begin
        out_d = '{out_value: 16'sh7fff, saturated: 1'b1, window_error: 1'b0};
      end else if (res < -AccW'(32768)) begin
        out_d = '{out_value: 16'sh8000, saturated: 1'b1, window_error: 1'b0};
      end else begin
        out_d = '{out_value: res[15:0], saturated: sat_q, window_error: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0; rd_last_q <= 1'b0; mul_v_q <= 1'b0; mul_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.mac;
      rd_last_q <= cmd_i.mac_last;
      mul_v_q <= rd_v_q;
      mul_last_q <= rd_last_q;
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign status_o.mac_busy = rd_v_q || mul_v_q || mul_last_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// ===== verif/conv_checker.sv =====
module conv_checker
  import dconv_pkg::*;
(
  input  logic                clk_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint AccMax = 64'sd549755813887;
  localparam longint AccMin = -64'sd549755813888;

  logic signed [15:0] pixel_mem [PixDepth];
  logic signed [15:0] weight_mem [WgtDepth];
  logic signed [15:0] bias_mem [MaxOutChannels];
  cfg_t cfg = '{kernel_width: 4'd3, kernel_height: 4'd3, dil_col: 4'd1,
                dil_row: 4'd1, step_col: 4'd1, step_row: 4'd1,
                bias_on: 1'b0, in_channels: 5'd1};
  out_item_t expected_q [$];
  int fails = 0;

  assign fail_count_o = fails;
  assign pending_o = expected_q.size();

  function automatic out_item_t conv_point(int row, int col, int oc);
    out_item_t r;
    int kw, kh, nc, r0, c0, pr, pc;
    longint acc, res;
    bit sat;
    kw = (cfg.kernel_width > MaxKernel) ? MaxKernel : cfg.kernel_width;
    kh = (cfg.kernel_height > MaxKernel) ? MaxKernel : cfg.kernel_height;
    nc = (cfg.in_channels > MaxInChannels) ? MaxInChannels : cfg.in_channels;
    r0 = row * cfg.step_row;
    c0 = col * cfg.step_col;
    r = '0;
    if (kw > 0 && kh > 0 &&
        (r0 + (kh - 1) * cfg.dil_row >= MaxImageHeight ||
         c0 + (kw - 1) * cfg.dil_col >= MaxImageWidth)) begin
      r.window_error = 1'b1;
      return r;
    end
    acc = cfg.bias_on ? longint'(bias_mem[oc]) * 256 : 0;
    sat = 1'b0;
    for (int i = 0; i < kh; i++) begin
      pr = r0 + i * cfg.dil_row;
      for (int j = 0; j < kw; j++) begin
        pc = c0 + j * cfg.dil_col;
        for (int k = 0; k < nc; k++) begin
          acc += longint'(pixel_mem[(pr * MaxImageWidth + pc) * MaxInChannels + k]) *
                 longint'(weight_mem[((oc * MaxKernel + i) * MaxKernel + j) *
                                     MaxInChannels + k]);
          if (acc > AccMax) begin
            acc = AccMax;
            sat = 1'b1;
          end
          if (acc < AccMin) begin
            acc = AccMin;
            sat = 1'b1;
          end
        end
      end
    end
    res = (acc + 128) >>> 8;
    if (res > 32767) begin
      res = 32767;
      sat = 1'b1;
    end
    if (res < -32768) begin
      res = -32768;
      sat = 1'b1;
    end
    r.out_value = res[15:0];
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegKernelWidth:  cfg.kernel_width = cfg_data_i[3:0];
        RegKernelHeight: cfg.kernel_height = cfg_data_i[3:0];
        RegDilationH:    cfg.dil_col = cfg_data_i[3:0];
        RegDilationV:    cfg.dil_row = cfg_data_i[3:0];
        RegStrideH:      cfg.step_col = cfg_data_i[3:0];
        RegStrideV:      cfg.step_row = cfg_data_i[3:0];
        RegBiasOn:       cfg.bias_on = cfg_data_i[0];
        RegInChannels:   cfg.in_channels = cfg_data_i;
        default: ;
      endcase
    end
    if (out_valid_i && out_ready_i) begin
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result beat %p", out_data_i);
      end else begin
        exp_item = expected_q.pop_front();
        if (out_data_i !== exp_item) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: expected value %0d sat %b win %b, got value %0d sat %b win %b",
                     exp_item.out_value, exp_item.saturated, exp_item.window_error,
                     out_data_i.out_value, out_data_i.saturated, out_data_i.window_error);
        end
      end
    end
    if (in_valid_i && in_ready_i) begin
      case (action_e'(in_data_i.action))
        ActLoadPixel:
          pixel_mem[{in_data_i.row, in_data_i.col, in_data_i.in_channel}] = in_data_i.value;
        ActLoadWeight:
          weight_mem[{in_data_i.out_channel, in_data_i.kernel_row, in_data_i.kernel_col,
                      in_data_i.in_channel}] = in_data_i.value;
        ActLoadBias:
          bias_mem[in_data_i.out_channel] = in_data_i.value;
        default:
          expected_q.push_back(conv_point(in_data_i.row, in_data_i.col,
                                          in_data_i.out_channel));
      endcase
    end
  end
endmodule

// ===== verif/tb.sv =====
module tb;
  import dconv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int fail_count, pending;
  int quiet_cycles = 0;
  bit no_stall = 1'b0;
  int rx_hold = 0;
  int sent = 0;

  bit pix_written [PixDepth];
  bit wgt_written [WgtDepth];
  bit bias_written [MaxOutChannels];
  int kw = 3, kh = 3, dil_h = 1, dil_v = 1, st_h = 1, st_v = 1, bias_en = 0, nch = 1;

  dconv_in_if in_if ();
  dconv_out_if out_if ();

  direct_conv2d_dot_product u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  conv_checker u_checker (
    .clk_i        (clk),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_data_i    (in_if.data),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_data_i   (out_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_stall || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready = 1'b0;
    end else if (rx_hold > 0) begin
      out_if.ready = 1'b0;
      rx_hold--;
    end else begin
      out_if.ready = 1'b1;
      if ($urandom_range(0, 3) == 0) rx_hold = pick_gap();
    end
  end

  function automatic logic signed [15:0] rand_val();
    int p;
    p = $urandom_range(0, 99);
    if (p < 12) return 16'sh8000;
    if (p < 24) return 16'sh7fff;
    if (p < 30) return 16'sh0000;
    if (p < 60) return 16'($urandom_range(0, 1023) - 512);
    return 16'($urandom());
  endfunction

  function automatic in_item_t rand_item();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[$bits(in_item_t)-1:0];
  endfunction

  task automatic send_beat(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data = it;
    do @(posedge clk); while (!in_if.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic load_pixel(int r, int c, int ic, logic signed [15:0] v);
    in_item_t it;
    it = rand_item();
    it.action = ActLoadPixel;
    it.row = 6'(r);
    it.col = 6'(c);
    it.in_channel = 4'(ic);
    it.value = v;
    pix_written[{it.row, it.col, it.in_channel}] = 1'b1;
    send_beat(it);
  endtask

  task automatic load_weight(int oc, int kr, int kc, int ic, logic signed [15:0] v);
    in_item_t it;
    it = rand_item();
    it.action = ActLoadWeight;
    it.out_channel = 4'(oc);
    it.kernel_row = 3'(kr);
    it.kernel_col = 3'(kc);
    it.in_channel = 4'(ic);
    it.value = v;
    wgt_written[{it.out_channel, it.kernel_row, it.kernel_col, it.in_channel}] = 1'b1;
    send_beat(it);
  endtask

  task automatic load_bias(int oc, logic signed [15:0] v);
    in_item_t it;
    it = rand_item();
    it.action = ActLoadBias;
    it.out_channel = 4'(oc);
    it.value = v;
    bias_written[oc] = 1'b1;
    send_beat(it);
  endtask

  // load every entry the point reads that holds no data yet, then compute it
  task automatic compute_point(int r, int c, int oc, bit fixed_on = 0,
                               logic signed [15:0] fixed_v = 0);
    in_item_t it;
    int ckw, ckh, cnc, pr, pc;
    ckw = (kw > MaxKernel) ? MaxKernel : kw;
    ckh = (kh > MaxKernel) ? MaxKernel : kh;
    cnc = (nch > MaxInChannels) ? MaxInChannels : nch;
    if (!(ckw > 0 && ckh > 0 && (r * st_v + (ckh - 1) * dil_v >= MaxImageHeight ||
                                  c * st_h + (ckw - 1) * dil_h >= MaxImageWidth))) begin
      if (bias_en && !bias_written[oc]) load_bias(oc, fixed_on ? fixed_v : rand_val());
      for (int i = 0; i < ckh; i++) begin
        for (int j = 0; j < ckw; j++) begin
          pr = r * st_v + i * dil_v;
          pc = c * st_h + j * dil_h;
          for (int k = 0; k < cnc; k++) begin
            if (!pix_written[(pr * MaxImageWidth + pc) * MaxInChannels + k])
              load_pixel(pr, pc, k, fixed_on ? fixed_v : rand_val());
            if (!wgt_written[((oc * MaxKernel + i) * MaxKernel + j) * MaxInChannels + k])
              load_weight(oc, i, j, k, fixed_on ? fixed_v : rand_val());
          end
        end
      end
    end
    it = rand_item();
    it.action = ActCompute;
    it.row = 6'(r);
    it.col = 6'(c);
    it.out_channel = 4'(oc);
    send_beat(it);
  endtask

  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(int a_kw, int a_kh, int a_dh, int a_dv, int a_sh, int a_sv,
                            int a_b, int a_nc);
    int vals [8];
    wait_idle();
    vals = '{a_kw, a_kh, a_dh, a_dv, a_sh, a_sv, a_b, a_nc};
    for (int i = 0; i < 8; i++) begin
      cfg_we = 1'b1;
      cfg_idx = reg_idx_e'(i);
      cfg_data = 5'(vals[i]);
      @(negedge clk);
    end
    cfg_we = 1'b0;
    {kw, kh, dil_h, dil_v, st_h, st_v, bias_en, nch} = {a_kw, a_kh, a_dh, a_dv, a_sh, a_sv,
                                                        a_b, a_nc};
  endtask

  // keep positions near the origin so loaded pixels are reused
  function automatic int row_limit(int k, int d, int s);
    int span, lim;
    if (k > MaxKernel) k = MaxKernel;
    span = (k > 0) ? (k - 1) * d : 0;
    if (span > 63) return 0;
    lim = (s == 0) ? 63 : (63 - span) / s;
    return (lim > 7) ? 7 : lim;
  endfunction

  task automatic random_phase(int budget);
    int p, r, c, oc, start;
    start = sent;
    while (sent - start < budget) begin
      p = $urandom_range(0, 99);
      if (p < 15) begin
        load_pixel($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 15),
                   rand_val());
      end else if (p < 25) begin
        load_weight($urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 15), rand_val());
      end else if (p < 30) begin
        load_bias($urandom_range(0, 15), rand_val());
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          r = $urandom_range(0, 63);
          c = $urandom_range(0, 63);
        end else begin
          r = $urandom_range(0, row_limit(kh, dil_v, st_v));
          c = $urandom_range(0, row_limit(kw, dil_h, st_h));
        end
        oc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
        compute_point(r, c, oc);
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    load_pixel(63, 63, 15, 16'sh7fff);
    load_weight(15, 7, 7, 15, 16'sh8000);
    load_bias(15, 16'sh8000);
    compute_point(0, 0, 0, 1, 16'sh8000);
    compute_point(1, 0, 1, 1, 16'sh7fff);
    compute_point(61, 61, 15);
    compute_point(62, 0, 2);
    compute_point(0, 62, 3);
    compute_point(63, 63, 0);
    compute_point(5, 7, 4);

    set_config(8, 8, 1, 1, 1, 1, 1, 1);
    compute_point(0, 0, 5, 1, 16'sh8000);
    compute_point(56, 56, 5);

    set_config(2, 3, 3, 2, 2, 3, 1, 2);
    random_phase(160);
    set_config(0, 0, 0, 0, 0, 0, 1, 0);
    random_phase(40);
    set_config(15, 1, 1, 1, 1, 1, 0, 1);
    random_phase(120);
    set_config(1, 15, 1, 1, 1, 1, 1, 31);
    random_phase(100);

    wait_idle();
    repeat (300) @(negedge clk);

    set_config(2, 2, 15, 15, 15, 15, 0, 3);
    random_phase(120);
    set_config(3, 3, 8, 8, 8, 8, 1, 4);
    random_phase(120);
    no_stall = 1'b1;
    set_config(1, 1, 1, 1, 1, 1, 0, 1);
    random_phase(150);
    no_stall = 1'b0;
    set_config(3, 3, 1, 1, 1, 1, 1, 4);
    random_phase(160);
    set_config(4, 2, 2, 1, 1, 2, 1, 1);
    random_phase(150);

    wait_idle();
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
